// ===== hw/rtl/bedw_pkg.sv =====
// Package for the binary erosion window block: CSR register indexes, opcodes,
// result constants, the stage-to-stage geometry struct and the element shape function.
// No dependencies.
package bedw_pkg;

   typedef enum logic [1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1,
      REG_WINDOW_SIZE  = 2'd2
   } reg_index_type;

   localparam logic       OPCODE_PIXEL = 1'b0;
   localparam logic       OPCODE_DRAIN = 1'b1;
   localparam logic [6:0] KEPT_VALUE   = 7'd127;
   localparam logic [3:0] SQUARE_LIMIT = 4'd3;
   localparam int         FIFO_DEPTH   = 4;

   // Geometry of one result, carried from the control stage to the erosion stage.
   typedef struct packed {
      logic       emit;
      logic       last;
      logic       disk;
      logic [3:0] radius;
      logic [4:0] base;    // line-store slot of the top row of the window
      logic [3:0] above;   // image rows above the center, saturated
      logic [3:0] below;
      logic [3:0] left;
      logic [3:0] right;
   } geom_type;

   // Element membership of window row i, window column j (column 0 is rightmost).
   function automatic logic elem_bit(input int r, input logic disk, input int i, input int j);
      int dx;
      int dy;
      dx = r - j;
      dy = i - r;
      if (i > 2 * r || j > 2 * r) begin
         return 1'b0;
      end
      if (disk) begin
         return (dx * dx + dy * dy) <= r * r;
      end
      return 1'b1;
   endfunction

endpackage

// ===== hw/rtl/bedw_erode.sv =====
// Erosion stage: holds the window of line-store columns and reduces it to one result.
// Depends on bedw_pkg for the geometry struct and the element shape function.
module bedw_erode #(
   parameter int MAX_RADIUS = 7
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       shift_en,
   input  logic [2*MAX_RADIUS:0]      col_in,
   input  bedw_pkg::geom_type         geom_in,
   output logic                       res_valid,
   output logic                       res_kept,
   output logic                       res_last
);
   localparam int NROWS = 2 * MAX_RADIUS + 1;
   localparam int SW    = $clog2(NROWS);

   logic [NROWS-1:0]   win_ff [NROWS];
   bedw_pkg::geom_type geom_ff;
   logic               emit_ff;

   logic [SW-1:0]      slot_of [NROWS];
   logic [SW:0]        slot_sum;
   logic [NROWS-1:0]   row_ok;
   logic [NROWS-1:0]   col_ok;
   logic               kept;
   int                 rad;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         win_ff[0] <= col_in;
         for (int k = 1; k < NROWS; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
      geom_ff <= geom_in;
      if (reset) begin
         emit_ff <= 1'b0;
      end else begin
         emit_ff <= geom_in.emit;
      end
   end

   always_comb begin
      rad = int'(geom_ff.radius);
      for (int i = 0; i < NROWS; i++) begin
         slot_sum = {1'b0, geom_ff.base[SW-1:0]} + (SW+1)'(i);
         slot_of[i] = (slot_sum >= (SW+1)'(NROWS)) ? SW'(slot_sum - (SW+1)'(NROWS))
                                                   : slot_sum[SW-1:0];
         row_ok[i] = (i < rad) ? ((rad - i) <= int'(geom_ff.above))
                               : ((i - rad) <= int'(geom_ff.below));
         col_ok[i] = (i < rad) ? ((rad - i) <= int'(geom_ff.right))
                               : ((i - rad) <= int'(geom_ff.left));
      end
   end

   always_comb begin
      kept = 1'b1;
      for (int i = 0; i < NROWS; i++) begin
         for (int j = 0; j < NROWS; j++) begin
            if (bedw_pkg::elem_bit(rad, geom_ff.disk, i, j) && row_ok[i] && col_ok[j]
                && !win_ff[j][slot_of[i]]) begin
               kept = 1'b0;
            end
         end
      end
   end

   assign res_valid = emit_ff;
   assign res_kept  = kept;
   assign res_last  = geom_ff.last;

endmodule

// ===== hw/rtl/binary_erosion_disk_window.sv =====
// Streaming binary erosion with a square or disk element over a raster frame.
// A result word is registered in the read stage, the erosion stage and then the output queue.
// Throughput: one item per cycle unless stalled; one line-store read port, one column per item.
// Frames no larger than radius rows plus radius pixels stall req for catch-up column reads
// at frame end, one read per missing column position.
// Reset clears all counters and the output queue and loads width 1024, height 1024, size 3;
// the line store is not cleared.
module binary_erosion_disk_window #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   parameter int MAX_RADIUS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_out_pixel,
   output logic        rsp_frame_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   localparam int NROWS  = 2 * MAX_RADIUS + 1;
   localparam int SW     = $clog2(NROWS);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
   localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
   localparam int LAG_W  = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
   localparam int FP_W   = $clog2(bedw_pkg::FIFO_DEPTH);
   localparam int FC_W   = $clog2(bedw_pkg::FIFO_DEPTH + 1);

   // configuration
   logic [10:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [3:0]  wsize_ff, wsize_in;
   logic        cfg_we;
   logic [WCNT_W-1:0] w_eff;
   logic [HCNT_W-1:0] h_eff;
   logic [3:0]        r_eff;
   logic [3:0]        r_raw;
   logic              disk;
   logic [LAG_W-1:0]  lag;

   // frame control
   logic [COL_W-1:0] in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   logic [SW-1:0]    in_slot_ff, in_slot_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [SW-1:0]    out_slot_ff, out_slot_in;
   logic [LAG_W-1:0] d_ff, d_in;
   logic             complete_ff, complete_in;
   logic             owe_ff, owe_in;

   logic accept, catchup, credit_ok, do_write, do_scan, reach, emit, last;
   logic in_col_end, in_at_end, out_col_end, out_at_end;
   logic [HCNT_W-1:0] rows_below;
   logic [WCNT_W-1:0] cols_right;
   logic [SW:0]       base_sum;
   logic [SW-1:0]     base;
   bedw_pkg::geom_type geom;

   // line store and read stage
   logic [NROWS-1:0]   store [MAX_WIDTH];
   logic [NROWS-1:0]   rd_data_ff;
   logic               p1_scan_ff, p1_wr_ff, p1_wbit_ff;
   logic [SW-1:0]      p1_wslot_ff;
   bedw_pkg::geom_type p1_geom_ff;
   logic               p1_emit_ff;
   logic [NROWS-1:0]   col_merged;

   // erosion stage and output queue
   logic       res_valid, res_kept, res_last;
   logic [7:0] fifo_mem [bedw_pkg::FIFO_DEPTH];
   logic [FP_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FC_W-1:0] fifo_cnt_ff;
   logic            pop;
   logic [FC_W:0]   pending;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign cfg_we = psel & penable & pwrite;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      wsize_in  = wsize_ff;
      if (cfg_we) begin
         unique case (paddr[3:2])
            bedw_pkg::REG_IMAGE_WIDTH:  width_in  = pwdata[10:0];
            bedw_pkg::REG_IMAGE_HEIGHT: height_in = pwdata[12:0];
            bedw_pkg::REG_WINDOW_SIZE:  wsize_in  = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         bedw_pkg::REG_IMAGE_WIDTH:  prdata = {21'd0, width_ff};
         bedw_pkg::REG_IMAGE_HEIGHT: prdata = {19'd0, height_ff};
         bedw_pkg::REG_WINDOW_SIZE:  prdata = {28'd0, wsize_ff};
         default:                    prdata = 32'd0;
      endcase
   end

   always_comb begin
      if (width_ff == 11'd0) begin
         w_eff = WCNT_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WCNT_W'(MAX_WIDTH);
      end else begin
         w_eff = WCNT_W'(width_ff);
      end
      if (height_ff == 13'd0) begin
         h_eff = HCNT_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = HCNT_W'(MAX_HEIGHT);
      end else begin
         h_eff = HCNT_W'(height_ff);
      end
      disk = wsize_ff > bedw_pkg::SQUARE_LIMIT;
      if (!disk) begin
         r_raw = (wsize_ff == bedw_pkg::SQUARE_LIMIT) ? 4'd1 : 4'd0;
      end else begin
         r_raw = wsize_ff >> 1;
      end
      r_eff = (32'(r_raw) > MAX_RADIUS) ? 4'(MAX_RADIUS) : r_raw;
      lag   = LAG_W'(r_eff) * LAG_W'(w_eff) + LAG_W'(r_eff);
   end

   // ---------------- control stage ----------------
   assign pending   = (FC_W+1)'(fifo_cnt_ff) + (FC_W+1)'(p1_emit_ff) + (FC_W+1)'(res_valid);
   assign credit_ok = pending < (FC_W+1)'(bedw_pkg::FIFO_DEPTH);
   assign req_stall = owe_ff | ~credit_ok;
   assign accept    = req_valid & ~req_stall;
   assign catchup   = owe_ff & credit_ok;

   assign in_col_end  = WCNT_W'(in_col_ff) == w_eff - 1'b1;
   assign in_at_end   = in_col_end && (HCNT_W'(in_row_ff) == h_eff - 1'b1);
   assign out_col_end = WCNT_W'(out_col_ff) == w_eff - 1'b1;
   assign out_at_end  = out_col_end && (HCNT_W'(out_row_ff) == h_eff - 1'b1);

   assign do_write = accept & ~complete_ff & (req_opcode == bedw_pkg::OPCODE_PIXEL);
   assign do_scan  = do_write | (accept & complete_ff) | catchup;
   assign reach    = d_ff == lag;
   assign emit     = do_scan & reach;
   assign last     = emit & out_at_end;

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      complete_in = complete_ff;
      owe_in      = owe_ff;
      d_in        = d_ff + LAG_W'(do_scan) - LAG_W'(emit);
      if (do_scan) begin
         // the scan column keeps running past the frame end while results drain
         in_col_in = in_col_end ? '0 : in_col_ff + 1'b1;
         if (do_write && in_col_end) begin
            in_row_in  = in_row_ff + 1'b1;
            in_slot_in = (in_slot_ff == SW'(NROWS - 1)) ? '0 : in_slot_ff + 1'b1;
         end
      end
      if (do_write && in_at_end) begin
         complete_in = 1'b1;
         if (!reach) begin
            owe_in = 1'b1;
         end
      end
      if (catchup && reach) begin
         owe_in = 1'b0;
      end
      if (emit) begin
         out_col_in = out_col_end ? '0 : out_col_ff + 1'b1;
         if (out_col_end) begin
            out_row_in  = out_row_ff + 1'b1;
            out_slot_in = (out_slot_ff == SW'(NROWS - 1)) ? '0 : out_slot_ff + 1'b1;
         end
      end
      if (last || cfg_we) begin
         in_col_in   = '0;
         in_row_in   = '0;
         in_slot_in  = '0;
         out_col_in  = '0;
         out_row_in  = '0;
         out_slot_in = '0;
         complete_in = 1'b0;
         owe_in      = 1'b0;
         d_in        = '0;
      end
   end

   always_comb begin
      rows_below = h_eff - 1'b1 - HCNT_W'(out_row_ff);
      cols_right = w_eff - 1'b1 - WCNT_W'(out_col_ff);
      base_sum   = {1'b0, out_slot_ff} + (SW+1)'(NROWS) - (SW+1)'(r_eff);
      base       = (base_sum >= (SW+1)'(NROWS)) ? SW'(base_sum - (SW+1)'(NROWS))
                                                : base_sum[SW-1:0];
      geom.emit   = emit;
      geom.last   = out_at_end;
      geom.disk   = disk;
      geom.radius = r_eff;
      geom.base   = 5'(base);
      geom.above  = (out_row_ff > ROW_W'(15)) ? 4'd15 : out_row_ff[3:0];
      geom.below  = (rows_below > HCNT_W'(15)) ? 4'd15 : rows_below[3:0];
      geom.left   = (out_col_ff > COL_W'(15)) ? 4'd15 : out_col_ff[3:0];
      geom.right  = (cols_right > WCNT_W'(15)) ? 4'd15 : cols_right[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'd1024;
         height_ff   <= 13'd1024;
         wsize_ff    <= 4'd3;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         complete_ff <= 1'b0;
         owe_ff      <= 1'b0;
         d_ff        <= '0;
         p1_scan_ff  <= 1'b0;
         p1_emit_ff  <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         wsize_ff    <= wsize_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
         complete_ff <= complete_in;
         owe_ff      <= owe_in;
         d_ff        <= d_in;
         p1_scan_ff  <= do_scan;
         p1_emit_ff  <= emit;
      end
   end

   // ---------------- line store: bit write, column read ----------------
   always_ff @(posedge clock) begin
      if (do_write) begin
         store[in_col_ff][in_slot_ff] <= req_pixel_value != 8'd0;
      end
      if (do_scan) begin
         rd_data_ff <= store[in_col_ff];
      end
      p1_wr_ff    <= do_write;
      p1_wslot_ff <= in_slot_ff;
      p1_wbit_ff  <= req_pixel_value != 8'd0;
      p1_geom_ff  <= geom;
   end

   // forward the pixel written on the same edge as the column read
   always_comb begin
      col_merged = rd_data_ff;
      if (p1_wr_ff) begin
         col_merged[p1_wslot_ff] = p1_wbit_ff;
      end
   end

   bedw_erode #(
      .MAX_RADIUS(MAX_RADIUS)
   ) u_erode (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (p1_scan_ff),
      .col_in    (col_merged),
      .geom_in   ({p1_emit_ff, p1_geom_ff[$bits(bedw_pkg::geom_type)-2:0]}),
      .res_valid (res_valid),
      .res_kept  (res_kept),
      .res_last  (res_last)
   );

   // ---------------- output queue ----------------
   assign rsp_valid = fifo_cnt_ff != '0;
   assign pop       = rsp_valid & ~rsp_stall;
   assign rsp_out_pixel  = fifo_mem[rd_ptr_ff][7:1];
   assign rsp_frame_last = fifo_mem[rd_ptr_ff][0];

   always_ff @(posedge clock) begin
      if (res_valid) begin
         fifo_mem[wr_ptr_ff] <= {(res_kept ? bedw_pkg::KEPT_VALUE : 7'd0), res_last};
      end
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (res_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fifo_cnt_ff <= fifo_cnt_ff + FC_W'(res_valid) - FC_W'(pop);
      end
   end

   // ---------------- assertions ----------------
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && fifo_cnt_ff == FC_W'(bedw_pkg::FIFO_DEPTH) && !pop))
      else $error("output queue overflow");

   a_owe_after_complete: assert property (@(posedge clock) disable iff (reset)
      owe_ff |-> complete_ff)
      else $error("catch-up pending outside frame end");

   a_lead_bounded: assert property (@(posedge clock) disable iff (reset)
      d_ff <= lag)
      else $error("scan lead beyond window lag");

   a_drain_emits: assert property (@(posedge clock) disable iff (reset)
      (accept && complete_ff) |-> emit)
      else $error("item after frame end gave no result");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for binary_erosion_disk_window: directed table, then random frames.
// Holds its own erosion predictor; depends on bedw_pkg and the block's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_ROWS = 15;
   localparam int LINE_MAX   = 1024;
   localparam int RANDOM_ITEMS = 1650;

   typedef struct packed {
      logic [6:0] out_pixel;
      logic       frame_last;
   } erosion_word_type;

   typedef struct {
      bit         cfg;
      int         w;
      int         h;
      int         ws;
      logic       op;
      logic [7:0] pix;
      bit         typed;
      logic [6:0] ep;
      logic       el;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = bedw_pkg::OPCODE_PIXEL;
   logic [7:0]  req_pixel_value = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_out_pixel;
   logic        rsp_frame_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = 4'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // predictor state
   bit          fg_store [0:STORE_ROWS*LINE_MAX-1];
   int unsigned in_row, in_col, out_row, out_col;
   int unsigned cfg_w, cfg_h, cfg_ws;

   erosion_word_type eroded_q [$];
   int fail_count = 0;
   int items_taken = 0;
   int words_seen = 0;
   int frames_done = 0;
   bit long_hold_done = 1'b0;

   binary_erosion_disk_window DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_pixel(rsp_out_pixel), .rsp_frame_last(rsp_frame_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   function automatic int unsigned eff_w();
      int unsigned w;
      w = cfg_w;
      if (w < 1) w = 1;
      if (w > LINE_MAX) w = LINE_MAX;
      return w;
   endfunction

   function automatic int unsigned eff_h();
      int unsigned h;
      h = cfg_h;
      if (h < 1) h = 1;
      if (h > 4096) h = 4096;
      return h;
   endfunction

   function automatic int eff_r();
      int r;
      if (cfg_ws <= bedw_pkg::SQUARE_LIMIT) r = (cfg_ws == bedw_pkg::SQUARE_LIMIT) ? 1 : 0;
      else r = cfg_ws / 2;
      if (r > 7) r = 7;
      return r;
   endfunction

   function automatic bit fg_get(int row, int col);
      return fg_store[(row % STORE_ROWS) * LINE_MAX + col];
   endfunction

   function automatic bit kept_at(int row, int col, int w, int h, int r);
      int y;
      int x;
      if (!fg_get(row, col)) return 1'b0;
      for (int dy = -r; dy <= r; dy++) begin
         y = row + dy;
         if (y < 0 || y >= h) continue;
         for (int dx = -r; dx <= r; dx++) begin
            x = col + dx;
            if (x < 0 || x >= w) continue;
            if (cfg_ws > bedw_pkg::SQUARE_LIMIT && dx * dx + dy * dy > r * r) continue;
            if (!fg_get(y, x)) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // Advance the predicted state by one accepted word; returns 1 when a result is due.
   function automatic bit erosion_step(logic op, logic [7:0] pix,
                                       output erosion_word_type res);
      int unsigned w, h, total, lag, inpos, outpos;
      int r;
      w = eff_w();
      h = eff_h();
      r = eff_r();
      total = w * h;
      lag = r * w + r;
      inpos = in_row * w + in_col;
      outpos = out_row * w + out_col;
      res = '0;
      if (inpos < total) begin
         if (op == bedw_pkg::OPCODE_DRAIN) return 1'b0;
         fg_store[(in_row % STORE_ROWS) * LINE_MAX + in_col] = (pix != 8'd0);
         in_col++;
         if (in_col >= w) begin
            in_col = 0;
            in_row++;
         end
         inpos++;
      end
      if (outpos >= total) return 1'b0;
      if (inpos < total && inpos <= outpos + lag) return 1'b0;
      res.out_pixel = kept_at(out_row, out_col, w, h, r) ? bedw_pkg::KEPT_VALUE : 7'd0;
      res.frame_last = (outpos + 1 == total);
      if (res.frame_last) begin
         in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      end else begin
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return 1'b1;
   endfunction

   function automatic bit frame_open();
      return (in_row | in_col | out_row | out_col) != 0;
   endfunction

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 0;
      if (pick < 19) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drop valid, hold until every expected word is out, then let the pipeline settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (eroded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic csr_write(bedw_pkg::reg_index_type idx, int unsigned value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         bedw_pkg::REG_IMAGE_WIDTH: cfg_w = value & 32'h7FF;
         bedw_pkg::REG_IMAGE_HEIGHT: cfg_h = value & 32'h1FFF;
         default: cfg_ws = value & 32'hF;
      endcase
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
   endtask

   task automatic set_geometry(int w, int h, int ws);
      csr_write(bedw_pkg::REG_IMAGE_WIDTH, w);
      csr_write(bedw_pkg::REG_IMAGE_HEIGHT, h);
      csr_write(bedw_pkg::REG_WINDOW_SIZE, ws);
   endtask

   task automatic send_word(logic op, logic [7:0] pix, bit typed,
                            erosion_word_type typed_res);
      erosion_word_type res;
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pixel_value <= pix;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_taken++;
      if (erosion_step(op, pix, res)) begin
         eroded_q.push_back(typed ? typed_res : res);
         if (res.frame_last) frames_done++;
      end
      gap = idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [7:0] rand_pixel();
      // keep most pixels foreground so erosion keeps something
      if ($urandom_range(0, 9) < 8) return 8'($urandom_range(1, 255));
      return 8'd0;
   endfunction

   // One frame: pixels with stray early drains, then drains and surplus pixels to flush.
   task automatic random_frame();
      int unsigned total;
      total = eff_w() * eff_h();
      for (int unsigned k = 0; k < total; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            send_word(bedw_pkg::OPCODE_DRAIN, 8'($urandom), 1'b0, '0);
         end
         send_word(bedw_pkg::OPCODE_PIXEL, rand_pixel(), 1'b0, '0);
      end
      while (frame_open()) begin
         if ($urandom_range(0, 3) == 0) send_word(bedw_pkg::OPCODE_PIXEL, 8'($urandom), 1'b0, '0);
         else send_word(bedw_pkg::OPCODE_DRAIN, 8'($urandom), 1'b0, '0);
      end
   endtask

   dir_row_type dir_tab [21] = '{
      '{0, 0, 0, 0, bedw_pkg::OPCODE_DRAIN, 8'h00, 0, 7'd0, 0},   // early drain after reset
      '{1, 1, 1, 1, bedw_pkg::OPCODE_PIXEL, 8'hFF, 1, 7'd127, 1},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h00, 1, 7'd0, 1},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h01, 1, 7'd127, 1},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_DRAIN, 8'hAA, 0, 7'd0, 0},
      '{1, 1, 1, 15, bedw_pkg::OPCODE_PIXEL, 8'h80, 1, 7'd127, 1},
      '{1, 2, 1, 2, bedw_pkg::OPCODE_PIXEL, 8'hFF, 1, 7'd127, 0}, // size 2 acts as 1
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h00, 1, 7'd0, 1},
      '{1, 2, 2, 3, bedw_pkg::OPCODE_PIXEL, 8'hFF, 0, 7'd0, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'hFF, 0, 7'd0, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'hFF, 0, 7'd0, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h00, 0, 7'd0, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_DRAIN, 8'h00, 0, 7'd0, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h55, 0, 7'd0, 0},   // surplus pixel
      '{0, 0, 0, 0, bedw_pkg::OPCODE_DRAIN, 8'h00, 0, 7'd0, 0},
      '{1, 3, 2, 0, bedw_pkg::OPCODE_PIXEL, 8'hFF, 1, 7'd127, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'hFE, 1, 7'd127, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h00, 1, 7'd0, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h0F, 1, 7'd127, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'hF0, 1, 7'd127, 0},
      '{0, 0, 0, 0, bedw_pkg::OPCODE_PIXEL, 8'h00, 1, 7'd0, 1}
   };

   // receiver: random stalls, one long hold-off to back the block up
   initial begin
      @(negedge reset);
      forever begin
         if (!long_hold_done && items_taken >= 600) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
            repeat (1 + idle_len()) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      erosion_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (eroded_q.size() == 0) begin
            $error("unexpected result word: out_pixel %0d frame_last %0b",
                   rsp_out_pixel, rsp_frame_last);
            fail_count++;
         end else begin
            want = eroded_q.pop_front();
            if (rsp_out_pixel !== want.out_pixel) begin
               $error("out_pixel: expected %0d, actual %0d", want.out_pixel, rsp_out_pixel);
               fail_count++;
            end
            if (rsp_frame_last !== want.frame_last) begin
               $error("frame_last: expected %0b, actual %0b", want.frame_last, rsp_frame_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      erosion_word_type typed_res;
      for (int i = 0; i < STORE_ROWS * LINE_MAX; i++) fg_store[i] = 1'b0;
      in_row = 0; in_col = 0; out_row = 0; out_col = 0;
      cfg_w = 1024; cfg_h = 1024; cfg_ws = 3;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].cfg) begin
            wait_drained();
            set_geometry(dir_tab[i].w, dir_tab[i].h, dir_tab[i].ws);
         end
         typed_res.out_pixel = dir_tab[i].ep;
         typed_res.frame_last = dir_tab[i].el;
         send_word(dir_tab[i].op, dir_tab[i].pix, dir_tab[i].typed, typed_res);
      end

      // extremes: widest row, largest disk on a single pixel, out-of-range register values
      wait_drained();
      csr_write(bedw_pkg::REG_IMAGE_HEIGHT, 4096);
      csr_write(bedw_pkg::REG_IMAGE_HEIGHT, 8191);
      csr_write(bedw_pkg::REG_IMAGE_WIDTH, 1024);
      set_geometry(2047, 1, 1);
      random_frame();
      wait_drained();
      set_geometry(0, 0, 14);
      random_frame();

      while (items_taken < RANDOM_ITEMS) begin
         wait_drained();
         if ($urandom_range(0, 2) == 0) begin
            set_geometry($urandom_range(0, 12), $urandom_range(0, 8), $urandom_range(0, 15));
         end else begin
            case ($urandom_range(0, 2))
               0: csr_write(bedw_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 12));
               1: csr_write(bedw_pkg::REG_IMAGE_HEIGHT, $urandom_range(1, 8));
               default: csr_write(bedw_pkg::REG_WINDOW_SIZE, $urandom_range(0, 15));
            endcase
         end
         random_frame();
      end

      req_valid <= 1'b0;
      while (eroded_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Covered %0d input words, %0d result words, %0d frames over square and disk",
               items_taken, words_seen, frames_done);
      $display("elements, early drains, surplus pixels and a long output hold-off.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
